// ===== sv/clcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combined LCG package
// Shared constants, state type and bucket index function for the shuffled
// combined congruential generator.
// ----------------------------------------------------------------------------
package clcg_pkg;

   localparam int TABLE_SIZE = 32;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int WORD_W     = 31;
   localparam int MUL_W      = 16;
   localparam int PROD_W     = WORD_W + MUL_W;
   localparam int WARMUP     = TABLE_SIZE + 8;
   localparam int CNT_W      = $clog2(WARMUP);

   localparam logic [31:0] MOD_A   = 32'd2147483563;
   localparam logic [31:0] MOD_B   = 32'd2147483399;
   localparam logic [MUL_W-1:0] MUL_A = 16'd40014;
   localparam logic [MUL_W-1:0] MUL_B = 16'd40692;
   // 2^31 is congruent to these values modulo each modulus
   localparam logic [31:0] FOLD_A  = 32'h8000_0000 - MOD_A;
   localparam logic [31:0] FOLD_B  = 32'h8000_0000 - MOD_B;
   localparam logic [31:0] TOP_VAL = MOD_A - 32'd1;
   localparam logic [31:0] BUCKET  = 32'd1 + 32'(TOP_VAL / 32'(TABLE_SIZE));

   localparam logic [WORD_W-1:0] SEED_RESET   = 31'd11;
   localparam logic [WORD_W-1:0] SECOND_RESET = 31'd123456789;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RED,
      ST_UPD,
      ST_SEED_MUL,
      ST_SEED_RED
   } state_type;

   // Table entry picked by the previous output: value / BUCKET over constant
   // thresholds, top entry as the ceiling.
   function automatic logic [IDX_W-1:0] bucket_index(input logic [WORD_W-1:0] v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int k = 1; k < TABLE_SIZE; k++) begin
         if (32'(v) >= 32'(k) * BUCKET) begin
            idx = IDX_W'(k);
         end
      end
      return idx;
   endfunction

endpackage

// ===== sv/clcg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module clcg_ram #(
   parameter int DEPTH  = 32,
   parameter int WIDTH  = 31,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/clcg_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Combined LCG multiplier unit
// Registers both generator products, then folds each back below its modulus.
// ----------------------------------------------------------------------------
module clcg_mul (
   input  logic                        clock,
   input  logic                        start,
   input  logic [clcg_pkg::WORD_W-1:0] first_in,
   input  logic [clcg_pkg::WORD_W-1:0] second_in,
   output logic [clcg_pkg::WORD_W-1:0] first_next,
   output logic [clcg_pkg::WORD_W-1:0] second_next
);

   logic [clcg_pkg::PROD_W-1:0] prod_a_ff;
   logic [clcg_pkg::PROD_W-1:0] prod_b_ff;
   logic [clcg_pkg::PROD_W-1:0] prod_a_in;
   logic [clcg_pkg::PROD_W-1:0] prod_b_in;

   // hi * 2^31 + lo == hi * fold + lo (mod m); the sum stays below 2m
   function automatic logic [clcg_pkg::WORD_W-1:0] fold_mod(
      input logic [clcg_pkg::PROD_W-1:0] p,
      input logic [31:0]                 fold,
      input logic [31:0]                 m
   );
      logic [31:0] sum;
      sum = 32'(p[clcg_pkg::WORD_W-1:0])
          + 32'(p[clcg_pkg::PROD_W-1:clcg_pkg::WORD_W]) * fold;
      if (sum >= m) begin
         sum = sum - m;
      end
      return sum[clcg_pkg::WORD_W-1:0];
   endfunction

   assign prod_a_in = clcg_pkg::PROD_W'(first_in)  * clcg_pkg::PROD_W'(clcg_pkg::MUL_A);
   assign prod_b_in = clcg_pkg::PROD_W'(second_in) * clcg_pkg::PROD_W'(clcg_pkg::MUL_B);

   always_ff @(posedge clock) begin
      if (start) begin
         prod_a_ff <= prod_a_in;
         prod_b_ff <= prod_b_in;
      end
   end

   assign first_next  = fold_mod(prod_a_ff, clcg_pkg::FOLD_A, clcg_pkg::MOD_A);
   assign second_next = fold_mod(prod_b_ff, clcg_pkg::FOLD_B, clcg_pkg::MOD_B);

endmodule

// ===== sv/shuffled_combined_lcg_generator_core.sv =====
`timescale 1ns / 1ps
// Normal step: the accepting edge registers both products, ST_RED steps both
// generators and reads the table, ST_UPD registers the response. A seeding
// transaction (first after reset or reseed set) first runs the 40 warm-up
// steps of the shared multiplier plus one ST_MUL issue. Requests are taken in
// idle or in ST_UPD with the output register free. Reset: synchronous; the
// shuffle table is not cleared and is first filled when the first transaction seeds.
// ----------------------------------------------------------------------------
// Shuffled combined LCG generator core
// Two multiplicative congruential generators combined through a Bays-Durham
// shuffle table held in a synchronous RAM.
// ----------------------------------------------------------------------------
module shuffled_combined_lcg_generator_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [clcg_pkg::WORD_W-1:0] csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_reseed,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [clcg_pkg::WORD_W-1:0] rsp_value
);

   clcg_pkg::state_type state_ff, state_in;

   logic [clcg_pkg::WORD_W-1:0] seed_ff;
   logic [clcg_pkg::WORD_W-1:0] first_ff;
   logic [clcg_pkg::WORD_W-1:0] second_ff;
   logic [clcg_pkg::WORD_W-1:0] last_out_ff;
   logic                        seeded_ff;
   logic [clcg_pkg::CNT_W-1:0]  cnt_ff;
   logic [clcg_pkg::IDX_W-1:0]  idx_ff;
   logic                        rsp_valid_ff;
   logic [clcg_pkg::WORD_W-1:0] rsp_value_ff;

   logic                        req_accept;
   logic                        do_seed;
   logic                        out_free;
   logic                        seed_load;
   logic                        mul_start;
   logic                        step_red;
   logic                        warm_red;
   logic                        upd_fire;
   logic                        ram_re;
   logic                        ram_we;
   logic [clcg_pkg::IDX_W-1:0]  ram_waddr;
   logic [clcg_pkg::WORD_W-1:0] ram_wdata;
   logic [clcg_pkg::WORD_W-1:0] ram_rdata;
   logic [clcg_pkg::IDX_W-1:0]  idx_comb;
   logic [clcg_pkg::WORD_W-1:0] first_next;
   logic [clcg_pkg::WORD_W-1:0] second_next;
   logic [clcg_pkg::WORD_W-1:0] seed_eff;
   logic                        warm_last;
   logic                        warm_write;
   logic signed [clcg_pkg::WORD_W+1:0] diff;
   logic signed [clcg_pkg::WORD_W+1:0] diff_fold;

   // Output register frees when empty or when its transaction is taken
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign do_seed    = req_reseed || !seeded_ff;
   assign seed_eff   = (seed_ff == '0) ? clcg_pkg::WORD_W'(1) : seed_ff;
   assign warm_last  = (cnt_ff == '0);
   assign warm_write = (32'(cnt_ff) < 32'(clcg_pkg::TABLE_SIZE));
   assign idx_comb   = clcg_pkg::bucket_index(last_out_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clcg_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = do_seed ? clcg_pkg::ST_SEED_MUL : clcg_pkg::ST_RED;
            end
         end
         clcg_pkg::ST_MUL: begin
            state_in = clcg_pkg::ST_RED;
         end
         clcg_pkg::ST_RED: begin
            state_in = clcg_pkg::ST_UPD;
         end
         clcg_pkg::ST_UPD: begin
            if (out_free) begin
               if (req_accept) begin
                  state_in = do_seed ? clcg_pkg::ST_SEED_MUL : clcg_pkg::ST_RED;
               end else begin
                  state_in = clcg_pkg::ST_IDLE;
               end
            end
         end
         clcg_pkg::ST_SEED_MUL: begin
            state_in = clcg_pkg::ST_SEED_RED;
         end
         clcg_pkg::ST_SEED_RED: begin
            state_in = warm_last ? clcg_pkg::ST_MUL : clcg_pkg::ST_SEED_MUL;
         end
         default: begin
            state_in = clcg_pkg::ST_IDLE;
         end
      endcase
   end

   // Control outputs of the sequencer
   always_comb begin
      req_stall = 1'b1;
      mul_start = 1'b0;
      step_red  = 1'b0;
      warm_red  = 1'b0;
      upd_fire  = 1'b0;
      unique case (state_ff)
         clcg_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         clcg_pkg::ST_MUL: begin
            mul_start = 1'b1;
         end
         clcg_pkg::ST_RED: begin
            step_red = 1'b1;
         end
         clcg_pkg::ST_UPD: begin
            req_stall = !out_free;
            upd_fire  = out_free;
         end
         clcg_pkg::ST_SEED_MUL: begin
            mul_start = 1'b1;
         end
         clcg_pkg::ST_SEED_RED: begin
            warm_red = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
      // a plain step starts its multiply on the accepting edge
      if (req_accept && !do_seed) begin
         mul_start = 1'b1;
      end
   end

   assign seed_load = req_accept && do_seed;

   // Table traffic: warm-up fills top entry down to 0, a step refills its entry
   assign ram_re    = step_red;
   assign ram_we    = (warm_red && warm_write) || upd_fire;
   assign ram_waddr = warm_red ? cnt_ff[clcg_pkg::IDX_W-1:0] : idx_ff;
   assign ram_wdata = warm_red ? first_next : first_ff;

   // Shuffled entry minus second generator, folded into 1..TOP_VAL
   always_comb begin
      diff = $signed({2'b00, ram_rdata}) - $signed({2'b00, second_ff});
      diff_fold = diff;
      if (diff < $signed((clcg_pkg::WORD_W + 2)'(1))) begin
         diff_fold = diff + $signed({1'b0, clcg_pkg::TOP_VAL});
      end
   end

   clcg_mul u_mul (
      .clock       (clock),
      .start       (mul_start),
      .first_in    (first_ff),
      .second_in   (second_ff),
      .first_next  (first_next),
      .second_next (second_next)
   );

   clcg_ram #(
      .DEPTH (clcg_pkg::TABLE_SIZE),
      .WIDTH (clcg_pkg::WORD_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_comb),
      .rd_data (ram_rdata)
   );

   // Control and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clcg_pkg::ST_IDLE;
         seed_ff      <= clcg_pkg::SEED_RESET;
         first_ff     <= '0;
         second_ff    <= clcg_pkg::SECOND_RESET;
         last_out_ff  <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         // restart both generators from the seed
         if (seed_load) begin
            first_ff  <= seed_eff;
            second_ff <= seed_eff;
         end
         // warm-up advances the first generator only
         if (warm_red) begin
            first_ff <= first_next;
            if (warm_last) begin
               last_out_ff <= first_next;
               seeded_ff   <= 1'b1;
            end
         end
         if (step_red) begin
            first_ff  <= first_next;
            second_ff <= second_next;
         end
         if (upd_fire) begin
            last_out_ff  <= diff_fold[clcg_pkg::WORD_W-1:0];
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (seed_load) begin
         cnt_ff <= clcg_pkg::CNT_W'(clcg_pkg::WARMUP - 1);
      end else if (warm_red) begin
         cnt_ff <= cnt_ff - clcg_pkg::CNT_W'(1);
      end
      if (step_red) begin
         idx_ff <= idx_comb;
      end
      if (upd_fire) begin
         rsp_value_ff <= diff_fold[clcg_pkg::WORD_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule
